FILE: rtl/akrl_pkg.sv
// ----------------------------------------------------------------------------
// akrl_pkg
// Shared constants, register indexes and AES byte helpers for the keyed
// random literal core.
// ----------------------------------------------------------------------------
package akrl_pkg;

   localparam int AES_STAGES = 11;
   localparam int MOD_BITS   = 4;
   localparam int MOD_STAGES = 128 / MOD_BITS;
   localparam int NUM_STAGES = AES_STAGES + MOD_STAGES + 1;

   localparam logic [7:0] REG_CIPHER_KEY     = 8'd0;
   localparam logic [7:0] REG_FORMULA_NUMBER = 8'd1;
   localparam logic [7:0] REG_VARIABLE_COUNT = 8'd2;
   localparam logic [7:0] REG_CLAUSE_LENGTH  = 8'd3;

   localparam logic [0:255][7:0] SBOX = 2048'h
637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0add4a2af9ca472c0b7fd9326363ff7cc34a5e5f171d8311504c723c31896059a071280e2eb27b27509832c1a1b6e5aa0523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cfd0efaafb434d338545f9027f503c9fa851a3408f929d38f5bcb6da2110fff3d2cd0c13ec5f974417c4a77e3d645d197360814fdc222a908846eeb814de5e0bdbe0323a0a4906245cc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08ba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e613557b986c11d9ee1f8981169d98e949b1e87e9ce5528df8ca1890dbfe6426841992d0fb054bb16;

   typedef logic [127:0] block_type;

   function automatic logic [7:0] sub_byte(input logic [7:0] x);
      return SBOX[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

FILE: rtl/akrl_round.sv
// ----------------------------------------------------------------------------
// akrl_round
// One AES-128 encryption round together with the matching key schedule step.
// ----------------------------------------------------------------------------
module akrl_round
   import akrl_pkg::*;
#(
   parameter bit LAST = 1'b0
) (
   input  block_type  state_i,
   input  block_type  rkey_i,
   input  logic [7:0] rcon_i,
   output block_type  state_o,
   output block_type  rkey_o,
   output logic [7:0] rcon_o
);

   logic [7:0] s [16];
   logic [7:0] t [16];
   logic [7:0] m [16];
   logic [31:0] w0, w1, w2, w3, tmp, n0, n1, n2, n3;

   // next round key
   always_comb begin
      w0  = rkey_i[127:96];
      w1  = rkey_i[95:64];
      w2  = rkey_i[63:32];
      w3  = rkey_i[31:0];
      tmp = {sub_byte(w3[23:16]) ^ rcon_i, sub_byte(w3[15:8]),
             sub_byte(w3[7:0]), sub_byte(w3[31:24])};
      n0  = w0 ^ tmp;
      n1  = w1 ^ n0;
      n2  = w2 ^ n1;
      n3  = w3 ^ n2;
   end

   assign rkey_o = {n0, n1, n2, n3};
   assign rcon_o = xtime(rcon_i);

   // sub bytes, shift rows, mix columns
   always_comb begin
      for (int k = 0; k < 16; k++) begin
         s[k] = state_i[127-8*k -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[c*4+r] = sub_byte(s[((c + r) % 4) * 4 + r]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         if (LAST) begin
            for (int r = 0; r < 4; r++) begin
               m[c*4+r] = t[c*4+r];
            end
         end else begin
            for (int r = 0; r < 4; r++) begin
               m[c*4+r] = t[c*4+r] ^ t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3]
                          ^ xtime(t[c*4+r] ^ t[c*4+((r+1)%4)]);
            end
         end
      end
      for (int k = 0; k < 16; k++) begin
         state_o[127-8*k -: 8] = m[k] ^ rkey_o[127-8*k -: 8];
      end
   end

endmodule

FILE: rtl/akrl_mod_step.sv
// ----------------------------------------------------------------------------
// akrl_mod_step
// Shift a few ciphertext bits into the running remainder modulo 2n.
// ----------------------------------------------------------------------------
module akrl_mod_step
   import akrl_pkg::*;
(
   input  block_type   ct_i,
   input  logic [31:0] rem_i,
   input  logic [31:0] modulus_i,
   output block_type   ct_o,
   output logic [31:0] rem_o
);

   logic [32:0] acc;
   logic [31:0] r;

   always_comb begin
      r = rem_i;
      for (int k = 0; k < MOD_BITS; k++) begin
         acc = {r, ct_i[127-k]};
         if (acc >= {1'b0, modulus_i}) begin
            acc = acc - {1'b0, modulus_i};
         end
         r = acc[31:0];
      end
      rem_o = r;
      ct_o  = ct_i << MOD_BITS;
   end

endmodule

FILE: rtl/aes_keyed_random_literal_core.sv
// ----------------------------------------------------------------------------
// aes_keyed_random_literal_core
// Keyed random literal generator on a pipelined AES-128 core.
// ----------------------------------------------------------------------------
// Usage: write cipher_key, formula_number, variable_count and clause_length
// through the csr_ channel (index 0..3; other indexes are dropped) while no
// word is in flight. Each req_ word carries a 64-bit literal index; each
// rsp_ word returns one signed literal in 1..n or -n..-1.
// The pipeline has 44 stages: a key/plaintext stage, ten AES rounds (each
// also expanding its round key), 32 remainder stages taking four ciphertext
// bits each, and an output register. One word enters and one leaves per
// cycle when the receiver keeps rsp_ready high.
// Each stage holds its own valid bit and advances whenever the stage after
// it is empty or moving, so a stalled receiver fills bubbles first and then
// stops the pipe with nothing lost or repeated.
// Reset empties the pipeline and loads key 0, formula 0, variable count 1,
// clause length 0.
// ----------------------------------------------------------------------------
module aes_keyed_random_literal_core
   import akrl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [63:0]        csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [63:0]        req_literal_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_literal
);

   logic [63:0] cipher_key_ff, formula_number_ff;
   logic [30:0] variable_count_ff, clause_length_ff;
   logic [31:0] n_val, modulus;

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES:0]   rdy;

   block_type  aes_st_ff [AES_STAGES];
   block_type  aes_rk_ff [AES_STAGES];
   logic [7:0] aes_rc_ff [AES_STAGES];
   block_type  rnd_st [AES_STAGES-1];
   block_type  rnd_rk [AES_STAGES-1];
   logic [7:0] rnd_rc [AES_STAGES-1];

   block_type   mod_ct_ff  [MOD_STAGES];
   logic [31:0] mod_rem_ff [MOD_STAGES];
   block_type   stp_ct     [MOD_STAGES];
   logic [31:0] stp_rem    [MOD_STAGES];

   logic [31:0] literal_ff, literal_in, rem_last;
   block_type   key, ptext;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_key_ff     <= '0;
         formula_number_ff <= '0;
         variable_count_ff <= 31'd1;
         clause_length_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CIPHER_KEY:     cipher_key_ff     <= csr_data;
            REG_FORMULA_NUMBER: formula_number_ff <= csr_data;
            REG_VARIABLE_COUNT: variable_count_ff <= csr_data[30:0];
            REG_CLAUSE_LENGTH:  clause_length_ff  <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   assign n_val   = (variable_count_ff == '0) ? 32'd1 : {1'b0, variable_count_ff};
   assign modulus = {n_val[30:0], 1'b0};

   // stage handshake
   always_comb begin
      rdy[NUM_STAGES] = rsp_ready;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
      valid_in[0] = rdy[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = rdy[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // initial key addition
   assign key   = {cipher_key_ff, formula_number_ff};
   assign ptext = {1'b0, variable_count_ff, 1'b0, clause_length_ff, req_literal_index};

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         aes_st_ff[0] <= ptext ^ key;
         aes_rk_ff[0] <= key;
         aes_rc_ff[0] <= 8'h01;
      end
   end

   // AES rounds
   for (genvar g = 0; g < AES_STAGES - 1; g++) begin : g_round
      akrl_round #(
         .LAST (g == AES_STAGES - 2)
      ) u_round (
         .state_i (aes_st_ff[g]),
         .rkey_i  (aes_rk_ff[g]),
         .rcon_i  (aes_rc_ff[g]),
         .state_o (rnd_st[g]),
         .rkey_o  (rnd_rk[g]),
         .rcon_o  (rnd_rc[g])
      );

      always_ff @(posedge clock) begin
         if (rdy[g+1]) begin
            aes_st_ff[g+1] <= rnd_st[g];
            aes_rk_ff[g+1] <= rnd_rk[g];
            aes_rc_ff[g+1] <= rnd_rc[g];
         end
      end
   end

   // remainder modulo 2n, MSB first
   for (genvar j = 0; j < MOD_STAGES; j++) begin : g_mod
      if (j == 0) begin : g_first
         akrl_mod_step u_step (
            .ct_i      (aes_st_ff[AES_STAGES-1]),
            .rem_i     (32'd0),
            .modulus_i (modulus),
            .ct_o      (stp_ct[j]),
            .rem_o     (stp_rem[j])
         );
      end else begin : g_next
         akrl_mod_step u_step (
            .ct_i      (mod_ct_ff[j-1]),
            .rem_i     (mod_rem_ff[j-1]),
            .modulus_i (modulus),
            .ct_o      (stp_ct[j]),
            .rem_o     (stp_rem[j])
         );
      end

      always_ff @(posedge clock) begin
         if (rdy[AES_STAGES+j]) begin
            mod_ct_ff[j]  <= stp_ct[j];
            mod_rem_ff[j] <= stp_rem[j];
         end
      end
   end

   // fold the remainder into a signed literal
   assign rem_last   = mod_rem_ff[MOD_STAGES-1];
   assign literal_in = (rem_last < n_val) ? rem_last + 32'd1 : n_val - 32'd1 - rem_last;

   always_ff @(posedge clock) begin
      if (rdy[NUM_STAGES-1]) begin
         literal_ff <= literal_in;
      end
   end

   assign rsp_literal = signed'(literal_ff);

endmodule
